// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file mbps_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also evaluated during reset.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mbps_pkg.sv =====
`default_nettype none
package mbps_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned CFG_BYTES       = 16;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd5;

  localparam logic [ADDR_W-1:0] SEEN_MAX = '1;

  typedef struct packed {
    logic [8*CFG_BYTES-1:0] pattern;
    logic [CFG_BYTES-1:0]   care;
    logic [LEN_W-1:0]       len;
    logic [CNT_W-1:0]       max_matches;
    logic [ADDR_W-1:0]      addr_base;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] seen;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/mbps_cfg.sv =====
`default_nettype none
module mbps_cfg
  import mbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [CFG_BYTES-1:0]  care_r;
  logic [LEN_W-1:0]      len_r;
  logic [CNT_W-1:0]      max_r;
  logic [ADDR_W-1:0]     base_r;
  logic [ADDR_W-1:0]     addr_base_r;

  // The start address of a match is addr_base_r plus the byte count, so the
  // subtraction of the length is kept off the data path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      care_r      <= '0;
      len_r       <= LEN_W'(1);
      max_r       <= CNT_W'(1);
      base_r      <= '0;
      addr_base_r <= '1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LO: pat_lo_r <= cfg_wdata;
          REG_PAT_HI: pat_hi_r <= cfg_wdata;
          REG_CARE:   care_r   <= cfg_wdata[CFG_BYTES-1:0];
          REG_LEN:    len_r    <= cfg_wdata[LEN_W-1:0];
          REG_MAX:    max_r    <= cfg_wdata[CNT_W-1:0];
          REG_BASE:   base_r   <= cfg_wdata[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
      addr_base_r <= base_r - ADDR_W'(len_r);
    end
  end

  assign cfg.pattern     = {pat_hi_r, pat_lo_r};
  assign cfg.care        = care_r;
  assign cfg.len         = len_r;
  assign cfg.max_matches = max_r;
  assign cfg.addr_base   = addr_base_r;

endmodule
`default_nettype wire

// ===== rtl/mbps_front.sv =====
`default_nettype none
module mbps_front
  import mbps_pkg::*;
#(
  parameter int unsigned WIN_DEPTH = CFG_BYTES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_region_end,
  input  wire logic                      fire,
  output item_t                          item,
  output logic [WIN_DEPTH-1:0][7:0]      window
);

  logic [WIN_DEPTH-1:0][7:0] window_r;
  logic [ADDR_W-1:0]         cnt_r;
  logic [ADDR_W-1:0]         cnt_nxt;
  logic                      vld_r;
  logic                      last_r;
  logic [ADDR_W-1:0]         seen_r;

  assign cnt_nxt = (cnt_r == SEEN_MAX) ? cnt_r : cnt_r + ADDR_W'(1);

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (acc) begin
          window_r[g] <= in_data_byte;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (acc) begin
          window_r[g] <= window_r[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else if (acc) begin
      vld_r <= 1'b1;
      cnt_r <= in_region_end ? '0 : cnt_nxt;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      last_r <= in_region_end;
      seen_r <= cnt_nxt;
    end
  end

  assign item.vld  = vld_r;
  assign item.last = last_r;
  assign item.seen = seen_r;
  assign window    = window_r;

endmodule
`default_nettype wire

// ===== rtl/mbps_match.sv =====
`default_nettype none
module mbps_match
  import mbps_pkg::*;
#(
  parameter int unsigned WIN_DEPTH = CFG_BYTES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  item_t                          item,
  input  wire logic [WIN_DEPTH-1:0][7:0] window,
  input  cfg_t                           cfg,
  input  wire logic                      out_ready,
  output logic                           fire,
  output logic                           out_valid,
  output logic [ADDR_W-1:0]              out_match_address,
  output logic [CNT_W-1:0]               out_match_ordinal,
  output logic                           out_limit_reached
);

  localparam int unsigned IDXW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  logic              eq_ok;
  logic              len_ok;
  logic              seen_ok;
  logic              room;
  logic              hit;
  logic [6:0]        pos;
  logic [CNT_W-1:0]  found_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  ord_r;
  logic              lim_r;

  // Pattern byte i lines up with the window entry that arrived len-1-i bytes
  // before the newest one.
  always_comb begin
    eq_ok = 1'b1;
    pos   = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      pos = {2'b00, cfg.len} - 7'(i) - 7'd1;
      if ((7'(i) < {2'b00, cfg.len}) && cfg.care[i] &&
          (window[pos[IDXW-1:0]] != cfg.pattern[8*i +: 8])) begin
        eq_ok = 1'b0;
      end
    end
  end

  assign len_ok  = (cfg.len != '0) && ({1'b0, cfg.len} <= 6'(WIN_DEPTH));
  assign seen_ok = item.seen >= ADDR_W'(cfg.len);
  assign room    = found_r < cfg.max_matches;
  assign hit     = item.vld && len_ok && seen_ok && room && eq_ok;
  assign fire    = item.vld && (!hit || !out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (item.last) begin
          found_r <= '0;
        end else if (hit) begin
          found_r <= found_r + CNT_W'(1);
        end
      end
      if (hit && fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && fire) begin
      addr_r <= cfg.addr_base + item.seen;
      ord_r  <= found_r;
      lim_r  <= (found_r + CNT_W'(1)) == cfg.max_matches;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = addr_r;
  assign out_match_ordinal = ord_r;
  assign out_limit_reached = lim_r;

endmodule
`default_nettype wire

// ===== rtl/masked_byte_pattern_scanner.sv =====
// Channel   Handshake              Word
// in        in_valid / in_ready    in_data_byte, in_region_end
// out       out_valid / out_ready  out_match_address, out_match_ordinal, out_limit_reached
// cfg       cfg_we                 cfg_index, cfg_wdata
//
// One byte is accepted per cycle while in_ready is high; out_valid for a match
// rises once its last byte has passed the front item register and the output register.
// The window compare and the output register set the one-cycle rate.
// Reset is synchronous and clears the control registers and counters; the
// byte window is left as it is, since stale bytes are never compared.
// A stalled result blocks new bytes only when the next byte also matches.
`default_nettype none
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_region_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ADDR_W-1:0]          out_match_address,
  output logic [CNT_W-1:0]           out_match_ordinal,
  output logic                       out_limit_reached,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned WIN_DEPTH = (PATTERN_MAX < CFG_BYTES) ? PATTERN_MAX : CFG_BYTES;

  cfg_t                      cfg;
  item_t                     item;
  logic [WIN_DEPTH-1:0][7:0] window;
  logic                      fire;
  logic                      acc;

  assign in_ready = !item.vld || fire;
  assign acc      = in_valid && in_ready;

  mbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbps_front #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_data_byte  (in_data_byte),
    .in_region_end (in_region_end),
    .fire          (fire),
    .item          (item),
    .window        (window)
  );

  mbps_match #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_match (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (item),
    .window            (window),
    .cfg               (cfg),
    .out_ready         (out_ready),
    .fire              (fire),
    .out_valid         (out_valid),
    .out_match_address (out_match_address),
    .out_match_ordinal (out_match_ordinal),
    .out_limit_reached (out_limit_reached)
  );

endmodule
`default_nettype wire

// ===== rtl/mbps_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module mbps_checker
  import mbps_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [7:0]            in_data_byte,
  input wire logic                  in_region_end,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [ADDR_W-1:0]     out_match_address,
  input wire logic [CNT_W-1:0]      out_match_ordinal,
  input wire logic                  out_limit_reached,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  `CHK_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_match_address) && $stable(out_match_ordinal) && $stable(out_limit_reached)), "Stalled result word changed")
  `CHK_ASSERT(a_in_stall_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "Input stalled without a stalled result")
  `CHK_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> (!out_valid && in_ready), "Block not idle after reset")
  `CHK_ASSERT(a_ordinal_range, clk, rst_n, out_valid |-> (out_match_ordinal != {CNT_W{1'b1}}), "Match ordinal out of range")

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
`default_nettype wire
